FILE: rtl/core/bds_pkg.sv
// Shared types, constants and helpers of the box downsampler.
package bds_pkg;

    // Store and channel geometry
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_SHIFT = 4;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SUM_W     = 16;
    localparam int NCH       = 4;
    localparam int PIX_W     = 8;
    localparam int ROWS_W    = MAX_SHIFT;
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd3;

    localparam logic [PIX_W-1:0] OPAQUE = 8'hFF;

    // What the back end does with a queued item
    typedef enum logic [1:0] {
        K_ACCUM,    // add into the column sums
        K_FULL,     // add, emit sum >> 2*shift, clear column
        K_PART,     // add, emit sum / (size*rows), clear column
        K_PASS      // nearest mode: emit the pixel unchanged
    } bds_kind_e;

    typedef struct packed {
        logic [NCH-1:0][PIX_W-1:0] pix;   // lane 0 red, 1 green, 2 blue, 3 alpha
        logic [COL_W-1:0]          col;
        bds_kind_e                 kind;
        logic                      row_last;
        logic                      has_alpha;
        logic [2:0]                shift;
        logic [ROWS_W-1:0]         rows;
    } bds_entry_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_CALC,
        B_DIV,
        B_OUT
    } bds_bstate_e;

    // Clamp a sum to one channel
    function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] v);
        sat8 = (v > SUM_W'(OPAQUE)) ? OPAQUE : v[PIX_W-1:0];
    endfunction

    // Saturating add of a pixel into a column sum
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [PIX_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(v);
        sat_add = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bds_ram.sv
// Generic simple dual-port RAM with registered read.
module bds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bds_front.sv
// Front end: configuration registers, row/column tracking and item classification.
module bds_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bds_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tuser,
    input  logic                         clearing,
    input  logic                         q_full,
    output logic                         q_push,
    output bds_pkg::bds_entry_t          q_din
);
    import bds_pkg::*;

    logic              filter_reg, alpha_reg;
    logic [2:0]        shift_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [15:0]       src_col_reg, src_col_next;
    logic [4:0]        rib_reg, rib_next;

    logic [2:0]        shift_eff;
    logic [CFG_W-1:0]  width_eff;
    logic [ROWS_W-1:0] phase_mask, phase;
    logic [15:0]       col;
    logic              in_range, last_row, phase_last, phase_zero, accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= 1'b1;
            alpha_reg  <= 1'b1;
            shift_reg  <= 3'd1;
            width_reg  <= CFG_W'(MAX_WIDTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILTER: filter_reg <= cfg_data[0];
                CFG_ALPHA:  alpha_reg  <= cfg_data[0];
                CFG_SHIFT:  shift_reg  <= cfg_data[2:0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Position within the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            rib_reg     <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            rib_reg     <= rib_next;
        end
    end

    assign s_tready = !clearing && !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classification of the incoming pixel
    always_comb
    begin
        shift_eff  = (shift_reg > 3'(MAX_SHIFT)) ? 3'(MAX_SHIFT) : shift_reg;
        width_eff  = (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
        phase_mask = ROWS_W'((32'd1 << shift_eff) - 32'd1);
        phase      = src_col_reg[ROWS_W-1:0] & phase_mask;
        phase_last = (phase == phase_mask);
        phase_zero = (phase == '0);
        col        = src_col_reg >> shift_eff;
        in_range   = (col < 16'(width_eff));
        last_row   = ((32'(rib_reg) + 32'd1) >= (32'd1 << shift_eff));

        q_din.pix       = s_tdata;
        q_din.col       = col[COL_W-1:0];
        q_din.row_last  = ((col + 16'd1) == 16'(width_eff));
        q_din.has_alpha = alpha_reg;
        q_din.shift     = shift_eff;
        q_din.rows      = rib_reg[ROWS_W-1:0] + ROWS_W'(1);
        q_din.kind      = K_ACCUM;
        q_push          = 1'b0;

        if (in_range)
        begin
            if (filter_reg)
            begin
                q_push = accept;
                if (phase_last && last_row)
                begin
                    q_din.kind = K_FULL;
                end
                else if (phase_last && s_tuser)
                begin
                    q_din.kind = K_PART;
                end
            end
            else if (rib_reg == '0 && phase_zero)
            begin
                q_push     = accept;
                q_din.kind = K_PASS;
            end
        end

        // Counter update
        src_col_next = src_col_reg;
        rib_next     = rib_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                src_col_next = '0;
                rib_next     = (s_tuser || last_row) ? 5'd0 : rib_reg + 5'd1;
            end
            else if (src_col_reg != 16'hFFFF)
            begin
                src_col_next = src_col_reg + 16'd1;
            end
        end
    end

endmodule

FILE: rtl/core/bds_queue.sv
// Short register queue between the front and back ends.
module bds_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bds_pkg::bds_entry_t din,
    input  logic                pop,
    output bds_pkg::bds_entry_t dout,
    output logic                empty,
    output logic                full
);
    import bds_pkg::*;

    bds_entry_t        store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign dout  = store[rptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wptr_reg] <= din;
        end
    end

endmodule

FILE: rtl/core/bds_back.sv
// Back end: column-sum read-modify-write, averaging, divider and output register.
module bds_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  bds_pkg::bds_entry_t q_head,
    output logic                q_pop,
    output logic                clearing,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tlast
);
    import bds_pkg::*;

    bds_bstate_e state_reg, state_next;
    logic [COL_W-1:0]                 clr_reg, clr_next;
    bds_entry_t                       cur_reg, cur_next;
    logic [NCH-1:0][SUM_W-1:0]        div_reg, div_next;
    logic [NCH-1:0][ROWS_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [NCH-1:0][PIX_W-1:0]        res_reg, res_next;
    logic                             m_valid_reg, m_valid_next;
    logic [31:0]                      m_data_reg, m_data_next;
    logic                             m_last_reg, m_last_next;

    logic                             ram_we;
    logic [COL_W-1:0]                 ram_waddr, ram_raddr;
    logic [NCH*SUM_W-1:0]             ram_wdata, ram_rdata;

    logic [NCH-1:0][SUM_W-1:0]        sum_new;
    logic [NCH-1:0][SUM_W-1:0]        quo_step;
    logic [NCH-1:0][ROWS_W-1:0]       rem_step;
    logic [ROWS_W:0]                  trial [NCH];
    logic [3:0]                       avg_shift;

    bds_ram #(
        .WIDTH(NCH*SUM_W),
        .DEPTH(MAX_WIDTH)
    ) u_sums (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Updated sums and one restoring division step per lane
    always_comb
    begin
        avg_shift = {cur_reg.shift, 1'b0};
        for (int i = 0; i < NCH; i++)
        begin
            sum_new[i]  = sat_add(ram_rdata[i*SUM_W +: SUM_W], cur_reg.pix[i]);
            trial[i]    = {rem_reg[i], div_reg[i][SUM_W-1]};
            if (trial[i] >= {1'b0, cur_reg.rows})
            begin
                rem_step[i] = ROWS_W'(trial[i] - {1'b0, cur_reg.rows});
                quo_step[i] = {div_reg[i][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_step[i] = trial[i][ROWS_W-1:0];
                quo_step[i] = {div_reg[i][SUM_W-2:0], 1'b0};
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cur_reg.col;
        ram_wdata    = '0;
        ram_raddr    = q_head.col;

        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + COL_W'(1);
                if (clr_reg == COL_W'(MAX_WIDTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    res_next = q_head.pix;
                    state_next = (q_head.kind == K_PASS) ? B_OUT : B_CALC;
                end
            end
            B_CALC:
            begin
                ram_we = 1'b1;
                if (cur_reg.kind == K_ACCUM)
                begin
                    ram_wdata  = sum_new;
                    state_next = B_IDLE;
                end
                else if (cur_reg.kind == K_FULL)
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        res_next[i] = sat8(sum_new[i] >> avg_shift);
                    end
                    state_next = B_OUT;
                end
                else
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        div_next[i] = sum_new[i] >> cur_reg.shift;
                        rem_next[i] = '0;
                    end
                    step_next  = STEP_W'(SUM_W - 1);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                div_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        res_next[i] = sat8(quo_step[i]);
                    end
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {cur_reg.has_alpha ? res_reg[3] : OPAQUE,
                                    res_reg[2], res_reg[1], res_reg[0]};
                    m_last_next  = cur_reg.row_last;
                    state_next   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign clearing = (state_reg == B_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/core/box_downsample_rgba.sv
// Box-filter RGBA downsampler: source pixel stream in, reduced pixel stream out.
//
// Source pixels enter on s_axis (tlast on the last pixel of each row, tuser
// on every pixel of the image's last row). Output pixels leave on m_axis,
// tlast on the last pixel of each output row. The cfg port writes the four
// mode registers; write it only while the block is idle.
// The front end accepts one pixel a cycle, while the queue is not full, into
// a four-entry queue. The back end owns the column-sum RAM (one
// read-modify-write port pair) and takes one queued item at a time: a filter
// item reads and writes back its column sum, a partial block then runs the
// 16-step divider; outputs load the output register. Filter-mode throughput
// is thus set by the RAM read-modify-write. With the queue empty, an output
// passes B_IDLE, B_CALC (filter only), B_DIV (partial blocks only) and B_OUT,
// which sets m_axis_tvalid. After reset the block clears all 2048 column sums,
// one per cycle, with s_axis_tready low until the pass ends; configuration
// writes are taken throughout. A stalled receiver holds the output register,
// the back end waits, and the queue fills until s_axis_tready falls.
module box_downsample_rgba (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bds_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // red, green, blue, alpha
    input  logic                          s_axis_tlast,   // row_end
    input  logic [0:0]                    s_axis_tuser,   // final_row
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // out_red, out_green,
                                                          // out_blue, out_alpha
    output logic                          m_axis_tlast    // row_last
);
    import bds_pkg::*;

    logic       clearing, q_push, q_pop, q_empty, q_full;
    bds_entry_t q_din, q_head;

    bds_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .s_tuser  (s_axis_tuser[0]),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    bds_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .din  (q_din),
        .pop  (q_pop),
        .dout (q_head),
        .empty(q_empty),
        .full (q_full)
    );

    bds_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .clearing(clearing),
        .m_tvalid(m_axis_tvalid),
        .m_tready(m_axis_tready),
        .m_tdata (m_axis_tdata),
        .m_tlast (m_axis_tlast)
    );

    // No pixel is taken while the sums are being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready)
        else $error("pixel accepted during clearing pass");

    // The front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // The back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");

    // No output can exist before the clearing pass is over
    a_no_output_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !clearing)
        else $error("output during clearing pass");

endmodule

FILE: test/bds_checker.sv
// Checker for the box downsampler: tracks mode writes, predicts output pixels, compares them.
module bds_checker
    import bds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // red, green, blue, alpha
    input  logic                 s_axis_tlast,   // row_end
    input  logic [0:0]           s_axis_tuser,   // final_row
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [31:0]          m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic                 m_axis_tlast,   // row_last
    output int                   failures,
    output int                   pending,
    output int                   pixels_in,
    output int                   pixels_out,
    output int                   averaged_out
);

    localparam int ALPHA_LANE = 3;
    localparam int SUM_MAX    = (1 << SUM_W) - 1;
    localparam int COL_MAX    = 'hFFFF;

    // One output pixel: lanes red..alpha from the low end, row_last on top
    typedef struct packed {
        logic                      row_last;
        logic [NCH-1:0][PIX_W-1:0] chan;
    } out_pixel_t;

    // Shadow of the block's mode registers and column sums
    logic [SUM_W-1:0] col_sums [NCH][MAX_WIDTH];
    logic             mode_filter;
    logic             mode_alpha;
    logic [2:0]       mode_shift;
    logic [CFG_W-1:0] mode_width;
    int unsigned      src_col;
    int unsigned      block_row;
    out_pixel_t       expected_pixels [$];
    string            chan_names [NCH];

    initial chan_names = '{"red", "green", "blue", "alpha"};

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= 10)
            $display("MISMATCH at output pixel %0d: %s", pixels_out, what);
    endtask

    // Fold one source pixel into the column sums; queue the pixel it releases, if any
    task automatic predict_downsample(input logic [31:0] data, input logic row_end,
                                      input logic final_row);
        int unsigned shift, size, width, col, phase, div, t, avg;
        int          ch;
        logic        last_row;
        out_pixel_t  px;
        shift    = (mode_shift > MAX_SHIFT) ? MAX_SHIFT : mode_shift;
        size     = 1 << shift;
        width    = (mode_width > MAX_WIDTH) ? MAX_WIDTH : mode_width;
        col      = src_col >> shift;
        phase    = src_col & (size - 1);
        last_row = (block_row + 1 >= size);
        div      = size * (block_row + 1);
        px.row_last = (col + 1 == width);
        if (col < width) begin
            if (mode_filter) begin
                for (ch = 0; ch < NCH; ch++) begin
                    t = col_sums[ch][col] + data[ch*PIX_W +: PIX_W];
                    col_sums[ch][col] = (t > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(t);
                end
                // last pixel of a column on the block's last row, or on the image's last row
                if (phase == size - 1 && (last_row || final_row)) begin
                    for (ch = 0; ch < NCH; ch++) begin
                        if (last_row)
                            avg = col_sums[ch][col] >> (2 * shift);
                        else
                            avg = col_sums[ch][col] / div;
                        px.chan[ch] = (avg > OPAQUE) ? OPAQUE : PIX_W'(avg);
                        col_sums[ch][col] = '0;
                    end
                    if (!mode_alpha)
                        px.chan[ALPHA_LANE] = OPAQUE;
                    expected_pixels.push_back(px);
                    averaged_out++;
                end
            end else if (block_row == 0 && phase == 0) begin
                // nearest: first pixel of the first row of each block
                for (ch = 0; ch < NCH; ch++)
                    px.chan[ch] = data[ch*PIX_W +: PIX_W];
                if (!mode_alpha)
                    px.chan[ALPHA_LANE] = OPAQUE;
                expected_pixels.push_back(px);
            end
        end
        // row and block position
        if (row_end) begin
            src_col = 0;
            if (final_row || last_row)
                block_row = 0;
            else
                block_row = (block_row + 1) & 'h1F;
        end else if (src_col < COL_MAX) begin
            src_col++;
        end
    endtask

    task automatic check_output(input out_pixel_t got);
        out_pixel_t want;
        int         ch;
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel 0x%08h last=%0d",
                                      got.chan, got.row_last));
        end else begin
            want = expected_pixels.pop_front();
            for (ch = 0; ch < NCH; ch++)
                if (got.chan[ch] !== want.chan[ch])
                    report_mismatch($sformatf("%s expected %0d, got %0d", chan_names[ch],
                                              want.chan[ch], got.chan[ch]));
            if (got.row_last !== want.row_last)
                report_mismatch($sformatf("row_last expected %0d, got %0d",
                                          want.row_last, got.row_last));
        end
        pixels_out++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int ch = 0; ch < NCH; ch++)
                for (int i = 0; i < MAX_WIDTH; i++)
                    col_sums[ch][i] = '0;
            mode_filter  = 1'b1;
            mode_alpha   = 1'b1;
            mode_shift   = 3'd1;
            mode_width   = CFG_W'(MAX_WIDTH);
            src_col      = 0;
            block_row    = 0;
            expected_pixels.delete();
            failures     = 0;
            pending      = 0;
            pixels_in    = 0;
            pixels_out   = 0;
            averaged_out = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FILTER: mode_filter = cfg_data[0];
                    CFG_ALPHA:  mode_alpha  = cfg_data[0];
                    CFG_SHIFT:  mode_shift  = cfg_data[2:0];
                    CFG_WIDTH:  mode_width  = cfg_data;
                    default:    ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_output({m_axis_tlast, m_axis_tdata});
            if (s_axis_tvalid && s_axis_tready) begin
                predict_downsample(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
                pixels_in++;
            end
            pending = expected_pixels.size();
        end
    end

endmodule

FILE: test/box_downsample_rgba_test.sv
// Test top for the box downsampler: clock, reset, pixel images, mode writes and verdict.
module box_downsample_rgba_test;
    import bds_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 1460;
    localparam int HOLD_CYCLES    = 400;
    localparam int WIDE_COLS      = 256;
    localparam int PRESSURE_ITEMS = 48;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // red, green, blue, alpha
    logic                 s_axis_tlast;   // row_end
    logic [0:0]           s_axis_tuser;   // final_row
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // out_red, out_green, out_blue, out_alpha
    logic                 m_axis_tlast;   // row_last

    int failures, pending, pixels_in, pixels_out, averaged_out;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int item_stop     = 0;
    int settings_used = 0;
    int eff_shift     = 1;
    int eff_width     = MAX_WIDTH;

    box_downsample_rgba dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bds_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .failures      (failures),
        .pending       (pending),
        .pixels_in     (pixels_in),
        .pixels_out    (pixels_out),
        .averaged_out  (averaged_out)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cycle count and timeout
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d output pixels outstanding", cycle_count, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left     = 0;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One item on the source side; called at a falling edge, returns at one
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic [7:0] a, input logic row_end, input logic final_row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {a, b, g, r};
        s_axis_tlast  <= row_end;
        s_axis_tuser  <= final_row;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_random_pixel(input logic row_end, input logic final_row);
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), row_end, final_row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
    endtask

    task automatic set_mode(input logic filter, input logic alpha, input int shift,
                            input int width);
        write_reg(CFG_FILTER, filter);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_SHIFT, shift);
        write_reg(CFG_WIDTH, width);
        cfg_we    <= 1'b0;
        eff_shift  = (shift > MAX_SHIFT) ? MAX_SHIFT : shift;
        eff_width  = (width > MAX_WIDTH) ? MAX_WIDTH : width;
        settings_used++;
    endtask

    // Stop sending and let every expected pixel, and any pixel still in flight, come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Rows of width*size pixels (1 to 32 if that is 0 or above 64), the last one final;
    // some rows short or overlong. Sending stops once the phase budget is used up.
    task automatic send_image(input int rows);
        int size, base, len, row, i;
        size = 1 << eff_shift;
        for (row = 0; row < rows; row++) begin
            if (eff_width == 0 || eff_width * size > 64)
                base = $urandom_range(1, 32);
            else
                base = eff_width * size;
            len = base;
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(0, 1) ? $urandom_range(1, base)
                                           : base + $urandom_range(1, 2 * size);
            for (i = 0; i < len && items_sent < item_stop; i++)
                send_random_pixel(i == len - 1, row == rows - 1);
        end
    endtask

    // Pixels with random row and image flags
    task automatic send_noise(input int count);
        repeat (count)
            if (items_sent < item_stop)
                send_random_pixel($urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    endtask

    // Corner settings first, random ones after
    task automatic choose_mode(input int seg);
        int shift, width;
        case (seg)
            0: set_mode(1'b1, 1'b1, 7, 2);        // shift above the maximum
            1: set_mode(1'b1, 1'b0, 3, 0);        // zero width: nothing comes out
            2: set_mode(1'b0, 1'b1, 2, 4095);     // width above the column store
            3: set_mode(1'b0, 1'b0, 0, 1);        // nearest, opaque, one column
            4: set_mode(1'b1, 1'b1, 0, 16);       // every pixel gives one out
            default: begin
                shift = $urandom_range(0, 7);
                width = $urandom_range(1, 32 >> ((shift > MAX_SHIFT) ? MAX_SHIFT : shift));
                if ($urandom_range(0, 9) == 0)
                    width = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_WIDTH, 4095);
                set_mode($urandom_range(0, 3) != 0, $urandom_range(0, 1), shift, width);
            end
        endcase
    endtask

    // Stimulus
    initial
    begin
        int phase, seg, phase_start, i;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FILTER;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 2x2 blocks, two output columns
        set_mode(1'b1, 1'b1, 1, 2);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0);
        send_pixel(8'h05, 8'h06, 8'h07, 8'h08, 1'b1, 1'b0);
        // final row on the first row of a block: partial average
        send_pixel(8'h0A, 8'h14, 8'h1E, 8'h28, 1'b0, 1'b1);
        send_pixel(8'h1F, 8'hFF, 8'h00, 8'h81, 1'b0, 1'b1);
        send_pixel(8'hC8, 8'h07, 8'hFE, 8'h55, 1'b0, 1'b1);
        send_pixel(8'h64, 8'h80, 8'h7F, 8'hAA, 1'b1, 1'b1);
        // overlong final row: two pixels past the last column are dropped
        for (i = 0; i < 6; i++)
            send_pixel(8'(i * 51), 8'(255 - i), 8'h80, 8'h01, i == 5, 1'b1);
        // short row: column 0 keeps its sum into the next block
        send_pixel(8'h33, 8'h44, 8'h55, 8'h66, 1'b0, 1'b0);
        send_pixel(8'hEE, 8'hDD, 8'hCC, 8'hBB, 1'b1, 1'b0);
        settle();
        // nearest, opaque, one pixel per column
        set_mode(1'b0, 1'b0, 0, 3);
        send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 1'b1);
        settle();

        // Long output hold-off while pixels keep coming: the queue fills up
        set_mode(1'b1, 1'b1, 0, 16);
        hold_requests++;
        for (i = 0; i < PRESSURE_ITEMS; i++)
            send_random_pixel((i & 15) == 15, 1'b0);
        settle();

        // One long row, one output per pixel
        set_mode(1'b1, 1'b1, 0, WIDE_COLS);
        for (i = 0; i < WIDE_COLS; i++)
            send_random_pixel(i == WIDE_COLS - 1, 1'b1);

        // Random images under four idling patterns
        seg = 0;
        for (phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_idle_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_idle_pct = 87; end
                default: begin send_idle_pct = 33; recv_idle_pct = 33; end
            endcase
            phase_start = items_sent;
            item_stop   = phase_start + RANDOM_ITEMS / 4;
            while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
                settle();
                choose_mode(seg);
                // long output hold-off while pixels keep coming
                if (seg == 4)
                    hold_requests++;
                repeat ($urandom_range(1, 3))
                    send_image($urandom_range(1, (1 << eff_shift) + 2));
                if ($urandom_range(0, 3) == 0)
                    send_noise($urandom_range(8, 24));
                seg++;
            end
        end
        settle();

        $display("Sent %0d source pixels under %0d mode settings; %0d pixels out (%0d averaged).",
                 pixels_in, settings_used, pixels_out, averaged_out);
        $display("Ran with sender gaps, output stalls, a long hold-off, short and overlong rows.");
        if (failures == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d expected pixels never came", failures, pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
